FILE: src/tqd_pkg.sv
`timescale 1ns / 1ps

package tqd_pkg;

    // Field widths of the two channels.
    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 6;
    localparam int BYTE_W   = 8;

    // Encoder layout and counter defaults.
    localparam int NUM_ENC             = 3;
    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int REPORT_POS_W        = 24;

    // Report frame layout.
    localparam int FRAME_LEN   = 16;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
    localparam int CHECKSUM_W  = 16;
    localparam int SUM_W       = 12;

    localparam logic [BYTE_W-1:0] FRAME_SOF0 = 8'hDE;
    localparam logic [BYTE_W-1:0] FRAME_SOF1 = 8'hC0;
    localparam logic [BYTE_W-1:0] FRAME_PAD  = 8'h00;

    // Depth of the snapshot queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Request codes on the func field.
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BUFFER = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ERROR  = 2'd3;

    // Step codes of the x4 decoder.
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    // Everything the back part needs to send one report frame.
    typedef struct packed {
        logic [CHECKSUM_W-1:0]   checksum;
        logic [BYTE_W-1:0]       error_count;
        logic [BYTE_W-1:0]       buffer_count;
        logic [REPORT_POS_W-1:0] pos0;
        logic [REPORT_POS_W-1:0] pos1;
        logic [REPORT_POS_W-1:0] pos2;
    } frame_info_t;

    // Queue status seen by the front part, the back part and the top level.
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    // Full x4 quadrature decode of one A/B pair.
    function automatic step_t quad_step(input logic [1:0] old_ab, input logic [1:0] new_ab);
        step_t s;
        s = STEP_NONE;
        case ({old_ab, new_ab})
            4'h2, 4'h4, 4'hB, 4'hD: s = STEP_UP;
            4'h1, 4'h7, 4'h8, 4'hE: s = STEP_DOWN;
            default:                s = STEP_NONE;
        endcase
        return s;
    endfunction

    // Byte of the report frame at a given position.
    function automatic logic [BYTE_W-1:0] frame_byte_at(input frame_info_t f,
                                                        input logic [FRAME_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = FRAME_PAD;
        unique case (idx)
            4'd0:    b = FRAME_SOF0;
            4'd1:    b = FRAME_SOF1;
            4'd2:    b = f.checksum[15:8];
            4'd3:    b = f.checksum[7:0];
            4'd4:    b = f.error_count;
            4'd5:    b = f.buffer_count;
            4'd6:    b = f.pos0[23:16];
            4'd7:    b = f.pos0[15:8];
            4'd8:    b = f.pos0[7:0];
            4'd9:    b = f.pos1[23:16];
            4'd10:   b = f.pos1[15:8];
            4'd11:   b = f.pos1[7:0];
            4'd12:   b = f.pos2[23:16];
            4'd13:   b = f.pos2[15:8];
            4'd14:   b = f.pos2[7:0];
            default: b = FRAME_PAD;
        endcase
        return b;
    endfunction

endpackage

FILE: src/tqd_if.sv
`timescale 1ns / 1ps

// Request channel: function code and port sample.
interface tqd_in_if;
    logic                          valid;
    logic                          ready;
    logic [tqd_pkg::FUNC_W-1:0]    func;
    logic [tqd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

// Frame byte channel.
interface tqd_out_if;
    logic                          valid;
    logic                          ready;
    logic [tqd_pkg::BYTE_W-1:0]    frame_byte;
    logic                          frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

FILE: src/tqd_front.sv
`timescale 1ns / 1ps

module tqd_front #(
    parameter int COUNT_WIDTH = tqd_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tqd_in_if.sink                 samples,
    input  tqd_pkg::queue_status_t q_status,
    output logic                   push,
    output tqd_pkg::frame_info_t   snap
);
    import tqd_pkg::*;

    logic [SAMPLE_W-1:0]    prev_reg;
    logic [SAMPLE_W-1:0]    prev_next;
    logic [COUNT_WIDTH-1:0] pos_reg  [NUM_ENC];
    logic [COUNT_WIDTH-1:0] pos_next [NUM_ENC];
    logic [BYTE_W-1:0]      error_reg;
    logic [BYTE_W-1:0]      error_next;
    logic [BYTE_W-1:0]      buffer_reg;
    logic [BYTE_W-1:0]      buffer_next;
    logic                   accept;
    logic                   is_sample;
    logic [SUM_W-1:0]       sum;

    // Only a report request needs room in the queue; other requests never stall.
    assign samples.ready = (samples.func != FUNC_REPORT) || !q_status.full;
    assign accept        = samples.valid && samples.ready;
    assign is_sample     = accept && (samples.func == FUNC_SAMPLE);
    assign push          = accept && (samples.func == FUNC_REPORT);

    // Decode each encoder pair and step its counter.
    always_comb
    begin
        prev_next = prev_reg;
        if (is_sample)
        begin
            prev_next = samples.sample;
        end
        for (int k = 0; k < NUM_ENC; k++)
        begin
            pos_next[k] = pos_reg[k];
            if (is_sample)
            begin
                case (quad_step(prev_reg[2*k +: 2], samples.sample[2*k +: 2]))
                    STEP_UP:   pos_next[k] = pos_reg[k] + COUNT_WIDTH'(1);
                    STEP_DOWN: pos_next[k] = pos_reg[k] - COUNT_WIDTH'(1);
                    default:   pos_next[k] = pos_reg[k];
                endcase
            end
        end
    end

    // Event counters wrap at eight bits.
    always_comb
    begin
        error_next  = error_reg;
        buffer_next = buffer_reg;
        if (accept && (samples.func == FUNC_ERROR))
        begin
            error_next = error_reg + 8'd1;
        end
        if (accept && (samples.func == FUNC_BUFFER))
        begin
            buffer_next = buffer_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            error_reg  <= '0;
            buffer_reg <= '0;
            for (int k = 0; k < NUM_ENC; k++)
            begin
                pos_reg[k] <= '0;
            end
        end
        else
        begin
            prev_reg   <= prev_next;
            error_reg  <= error_next;
            buffer_reg <= buffer_next;
            for (int k = 0; k < NUM_ENC; k++)
            begin
                pos_reg[k] <= pos_next[k];
            end
        end
    end

    // Snapshot of the current state for a report, with its checksum.
    always_comb
    begin
        snap.error_count  = error_reg;
        snap.buffer_count = buffer_reg;
        snap.pos0         = pos_reg[0][REPORT_POS_W-1:0];
        snap.pos1         = pos_reg[1][REPORT_POS_W-1:0];
        snap.pos2         = pos_reg[2][REPORT_POS_W-1:0];
        sum = ((SUM_W'(error_reg)          + SUM_W'(buffer_reg))
             + (SUM_W'(snap.pos0[23:16])   + SUM_W'(snap.pos0[15:8])))
            + ((SUM_W'(snap.pos0[7:0])     + SUM_W'(snap.pos1[23:16]))
             + (SUM_W'(snap.pos1[15:8])    + SUM_W'(snap.pos1[7:0])))
            + ((SUM_W'(snap.pos2[23:16])   + SUM_W'(snap.pos2[15:8]))
             + SUM_W'(snap.pos2[7:0]));
        snap.checksum = ~CHECKSUM_W'(sum);
    end

endmodule

FILE: src/tqd_queue.sv
`timescale 1ns / 1ps

module tqd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tqd_pkg::frame_info_t   push_data,
    input  logic                   pop,
    output tqd_pkg::frame_info_t   head,
    output tqd_pkg::queue_status_t status
);
    import tqd_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_info_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign head             = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/tqd_back.sv
`timescale 1ns / 1ps

module tqd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tqd_pkg::frame_info_t   head,
    input  tqd_pkg::queue_status_t q_status,
    output logic                   pop,
    tqd_out_if.source              frames
);
    import tqd_pkg::*;

    frame_info_t            frame_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    logic [FRAME_IDX_W-1:0] idx_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   last;
    logic                   taken;

    assign last              = (idx_reg == FRAME_IDX_W'(FRAME_LEN - 1));
    assign taken             = valid_reg && frames.ready;
    assign pop               = q_status.not_empty && (!valid_reg || (taken && last));
    assign frames.valid      = valid_reg;
    assign frames.frame_byte = frame_byte_at(frame_reg, idx_reg);
    assign frames.frame_last = valid_reg && last;

    // Byte sequencer: step through the frame, load the next one when idle or on its last byte.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + FRAME_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= head;
        end
    end

endmodule

FILE: src/triple_quadrature_decoder_reporter_unit.sv
`timescale 1ns / 1ps

// Triple x4 quadrature decoder with a checksummed report frame.
// The samples channel carries a function code and a 6-bit port sample with
// three A/B pairs. Port samples, buffer-done and error requests are taken in
// every cycle and update the position and event counters at once; they never
// stall. A report request takes a snapshot of the counters and its checksum
// into a two-entry queue; it is held off only while that queue is full.
// The frames channel sends each report as 16 bytes, frame_last on the last.
// When the frame sender is idle, the first byte appears once the snapshot has
// been written into the queue and loaded into the byte sequencer, and one byte
// leaves per cycle while the receiver takes them, so a sustained stream of reports
// is paced by the byte sequencer. A new frame starts right after the last byte of the previous one.
// When the receiver stalls, the current byte holds and the queue fills; other
// requests keep flowing. Reset clears all counters, the previous sample, the
// queue and the byte sequencer.

module triple_quadrature_decoder_reporter_unit #(
    parameter int COUNT_WIDTH = tqd_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tqd_in_if.sink     samples,
    tqd_out_if.source  frames
);
    import tqd_pkg::*;

    queue_status_t q_status;
    frame_info_t   snap;
    frame_info_t   head;
    logic          push;
    logic          pop;

    tqd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .push     (push),
        .snap     (snap)
    );

    tqd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (snap),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    tqd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .frames   (frames)
    );

    // A report request is never taken into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("report request accepted while snapshot queue full");

    // A newly loaded frame starts with its first sync byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (frames.valid && (frames.frame_byte == FRAME_SOF0) && !frames.frame_last))
        else $error("frame does not start with sync byte");

    // With nothing queued, the channel goes idle after the last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.ready && frames.frame_last && !q_status.not_empty)
        |=> !frames.valid)
        else $error("output valid after last byte with empty queue");

    // The byte after a taken last byte, when there is one, is a sync byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.ready && frames.frame_last) |=>
        (!frames.valid || (frames.frame_byte == FRAME_SOF0)))
        else $error("frame boundary lost");

endmodule

FILE: tb/triple_quadrature_decoder_reporter_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder. It keeps its own copy of the counters,
// builds the expected report frame for every accepted report request, and
// compares each accepted frame byte with the oldest expected byte.
module triple_quadrature_decoder_reporter_checker #(
    parameter int COUNT_WIDTH = tqd_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    tqd_in_if    req_ch,
    tqd_out_if   byte_ch,
    output int   fail_count,
    output int   bytes_due,
    output int   frames_seen
);
    import tqd_pkg::*;

    // One expected beat on the frame channel.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } frame_beat_t;

    frame_beat_t            report_bytes_due[$];
    logic [SAMPLE_W-1:0]    last_port;
    logic [COUNT_WIDTH-1:0] position [NUM_ENC];
    logic [BYTE_W-1:0]      error_tally;
    logic [BYTE_W-1:0]      buffer_tally;

    // A forward step moves 00 -> 10 -> 11 -> 01 -> 00; the reverse is a backward step.
    // Anything else, a double-bit jump or no change, does not move the counter.
    function automatic step_t pair_motion(input logic [1:0] was_ab, input logic [1:0] now_ab);
        if (was_ab == now_ab)
            return STEP_NONE;
        if (now_ab == {~was_ab[0], was_ab[1]})
            return STEP_UP;
        if (now_ab == {was_ab[0], ~was_ab[1]})
            return STEP_DOWN;
        return STEP_NONE;
    endfunction

    // Update the three position counters from a new port sample.
    task automatic apply_port_sample(input logic [SAMPLE_W-1:0] port);
        step_t motion;
        if (port != last_port)
        begin
            for (int k = 0; k < NUM_ENC; k++)
            begin
                motion = pair_motion(last_port[2*k +: 2], port[2*k +: 2]);
                if (motion == STEP_UP)
                    position[k] = position[k] + COUNT_WIDTH'(1);
                else if (motion == STEP_DOWN)
                    position[k] = position[k] - COUNT_WIDTH'(1);
            end
            last_port = port;
        end
    endtask

    // Build the sixteen bytes of a report frame and append them to the queue.
    task automatic queue_report_frame();
        logic [BYTE_W-1:0]     body [FRAME_LEN];
        logic [CHECKSUM_W-1:0] sum;
        frame_beat_t           beat;
        body[0]  = FRAME_SOF0;
        body[1]  = FRAME_SOF1;
        body[4]  = error_tally;
        body[5]  = buffer_tally;
        for (int k = 0; k < NUM_ENC; k++)
        begin
            body[6 + 3*k] = position[k][23:16];
            body[7 + 3*k] = position[k][15:8];
            body[8 + 3*k] = position[k][7:0];
        end
        body[15] = FRAME_PAD;
        sum = '0;
        for (int i = 4; i <= 14; i++)
            sum = sum + {8'd0, body[i]};
        sum = ~sum;
        body[2] = sum[15:8];
        body[3] = sum[7:0];
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            beat.value = body[i];
            beat.last  = (i == FRAME_LEN - 1);
            report_bytes_due.push_back(beat);
        end
    endtask

    // Compare accepted bytes first, then fold in the request taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            last_port    = '0;
            error_tally  = '0;
            buffer_tally = '0;
            for (int k = 0; k < NUM_ENC; k++)
                position[k] = '0;
            report_bytes_due.delete();
            fail_count  = 0;
            frames_seen = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (report_bytes_due.size() == 0)
                begin
                    $error("frame byte %h arrived with no report outstanding",
                           byte_ch.frame_byte);
                    fail_count++;
                end
                else
                begin
                    want = report_bytes_due.pop_front();
                    if (byte_ch.frame_byte !== want.value)
                    begin
                        $error("frame_byte: expected %h, actual %h",
                               want.value, byte_ch.frame_byte);
                        fail_count++;
                    end
                    if (byte_ch.frame_last !== want.last)
                    begin
                        $error("frame_last: expected %b, actual %b",
                               want.last, byte_ch.frame_last);
                        fail_count++;
                    end
                    if (want.last)
                        frames_seen++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                case (req_ch.func)
                    FUNC_SAMPLE: apply_port_sample(req_ch.sample);
                    FUNC_REPORT: queue_report_frame();
                    FUNC_BUFFER: buffer_tally = buffer_tally + BYTE_W'(1);
                    FUNC_ERROR:  error_tally = error_tally + BYTE_W'(1);
                    default:     ;
                endcase
            end
        end
        bytes_due = report_bytes_due.size();
    end

endmodule

FILE: tb/triple_quadrature_decoder_reporter_unit_test.sv
`timescale 1ns / 1ps

// Drives requests into the decoder, paces the frame receiver and gives the verdict.
module triple_quadrature_decoder_reporter_unit_test;
    import tqd_pkg::*;

    logic clk;
    logic rst_n;

    tqd_in_if  req_ch ();
    tqd_out_if byte_ch ();

    int fail_count;
    int bytes_due;
    int frames_seen;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int sent_count  = 0;
    int buffer_sent = 0;
    int error_sent  = 0;

    logic [SAMPLE_W-1:0] port_now = '0;
    bit                  heading [NUM_ENC];

    triple_quadrature_decoder_reporter_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (req_ch),
        .frames  (byte_ch)
    );

    triple_quadrature_decoder_reporter_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .byte_ch     (byte_ch),
        .fail_count  (fail_count),
        .bytes_due   (bytes_due),
        .frames_seen (frames_seen)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Frame receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left     = 0;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                byte_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One quadrature step of a pair, forward or backward.
    function automatic logic [1:0] gray_move(input logic [1:0] ab, input bit forward);
        return forward ? {~ab[0], ab[1]} : {ab[0], ~ab[1]};
    endfunction

    // Next port value of a well-formed encoder motion: each pair steps, mostly
    // along its heading, sometimes back, sometimes not at all.
    function automatic logic [SAMPLE_W-1:0] next_motion();
        logic [SAMPLE_W-1:0] s;
        int                  r;
        s = port_now;
        for (int k = 0; k < NUM_ENC; k++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                s[2*k +: 2] = gray_move(s[2*k +: 2], heading[k]);
            else if (r < 75)
                s[2*k +: 2] = gray_move(s[2*k +: 2], !heading[k]);
        end
        return s;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait until taken.
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.func   <= f;
        req_ch.sample <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
        if (f == FUNC_BUFFER)
            buffer_sent++;
        if (f == FUNC_ERROR)
            error_sent++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        port_now = s;
        send_request(FUNC_SAMPLE, s);
    endtask

    // One random request: encoder motion, some noise samples, reports and events.
    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 50)
        begin
            if ($urandom_range(99) < 85)
                send_sample(next_motion());
            else
                send_sample(SAMPLE_W'($urandom_range(63)));
        end
        else if (r < 62)
        begin
            send_request(FUNC_REPORT, SAMPLE_W'($urandom_range(63)));
        end
        else if (r < 81)
        begin
            send_request(FUNC_BUFFER, SAMPLE_W'($urandom_range(63)));
        end
        else
        begin
            send_request(FUNC_ERROR, SAMPLE_W'($urandom_range(63)));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < NUM_ENC; k++)
            heading[k] = 1'($urandom_range(1));
        repeat (count)
            random_item();
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_SAMPLE;
        req_ch.sample = '0;
        tx_idle_pct   = 31;
        rx_idle_pct   = 52;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: the frame right after reset.
        send_request(FUNC_REPORT, 6'd0);
        // Four forward steps on every pair, then a repeated sample.
        send_sample(6'b101010);
        send_sample(6'b111111);
        send_sample(6'b010101);
        send_sample(6'b000000);
        send_sample(6'b000000);
        // A report ignores its sample field.
        send_request(FUNC_REPORT, 6'd63);
        // Five backward steps take every counter below zero.
        send_sample(6'b010101);
        send_sample(6'b111111);
        send_sample(6'b101010);
        send_sample(6'b000000);
        send_sample(6'b010101);
        // Both bits flip at once: no count.
        send_sample(6'b101010);
        // Mixed directions on the three pairs.
        send_sample(6'b110011);
        send_request(FUNC_BUFFER, 6'd63);
        send_request(FUNC_ERROR, 6'd0);
        send_request(FUNC_ERROR, 6'd21);
        send_request(FUNC_REPORT, 6'd42);

        // Receiver idles more than the sender, with one long receiver hold-off
        // while reports keep coming, so the snapshot queue fills.
        run_phase(31, 52, 60);
        hold_req = 400;
        repeat (8)
            send_request(FUNC_REPORT, SAMPLE_W'($urandom_range(63)));
        run_phase(31, 52, 65);

        // Sender idles more than the receiver, then neither idles.
        run_phase(52, 31, 110);
        run_phase(0, 0, 110);
        send_request(FUNC_REPORT, 6'd0);

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain the frames still owed, then watch a while for stray bytes.
        while (bytes_due != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Run covered %0d requests (%0d buffer, %0d error) and %0d report frames,",
                 sent_count, buffer_sent, error_sent, frames_seen);
        $display("under three idle patterns, a long receiver hold-off and counter underflow.");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
